/* rtl/core/uart16_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart16_pkg
// Shared codes, register offsets, bit positions and transfer structs for the
// 16550-style register model.
// ----------------------------------------------------------------------------
package uart16_pkg;

	localparam logic [1:0] MODE_BUS_RD  = 2'd0;
	localparam logic [1:0] MODE_BUS_WR  = 2'd1;
	localparam logic [1:0] MODE_HOST_RX = 2'd2;

	localparam logic [2:0] OFF_DATA    = 3'd0;
	localparam logic [2:0] OFF_IER     = 3'd1;
	localparam logic [2:0] OFF_IIR_FCR = 3'd2;
	localparam logic [2:0] OFF_LCR     = 3'd3;
	localparam logic [2:0] OFF_MCR     = 3'd4;
	localparam logic [2:0] OFF_LSR     = 3'd5;
	localparam logic [2:0] OFF_MSR     = 3'd6;
	localparam logic [2:0] OFF_SCR     = 3'd7;

	localparam int LCR_DLAB_BIT   = 7;
	localparam int MCR_LOOP_BIT   = 4;
	localparam int FCR_CLR_RX_BIT = 1;
	localparam int IER_RDA_BIT    = 0;
	localparam int IER_THRE_BIT   = 1;

	localparam logic [3:0] IER_MASK       = 4'h0f;
	localparam logic [7:0] IIR_TYPE_BITS  = 8'hc0;
	localparam logic [7:0] IIR_NONE       = 8'h01;
	localparam logic [7:0] MSR_FIXED      = 8'hb0;
	localparam logic [7:0] LSR_TEMT_THRE  = 8'h60;
	localparam logic [7:0] MCR_RESET      = 8'h08;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_accepted;
	} rsp_t;

endpackage

/* rtl/core/uart16_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart16_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module uart16_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/uart16_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart16_regfile
// Register state, receive fifo and the combinational access update that
// produces one result per transfer.
// ----------------------------------------------------------------------------
module uart16_regfile #(
	parameter int RX_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  uart16_pkg::req_t  req,
	output uart16_pkg::rsp_t  rsp
);
	import uart16_pkg::*;

	localparam int CNT_W  = $clog2(RX_DEPTH + 1);
	localparam int ADDR_W = $clog2(RX_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RX_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [CNT_W-1:0] fill_q, fill_d, rd_q, rd_d, fill_inc, rd_inc;
	logic             burst_q, burst_d;
	logic             dr_q, dr_d;
	logic [7:0]       dll_q, dll_d, dlm_q, dlm_d;
	logic [3:0]       ier_q, ier_d;
	logic [7:0]       iir_q, iir_d;
	logic [7:0]       lcr_q, lcr_d, mcr_q, mcr_d, scr_q, scr_d;
	logic             irq_d;
	logic [7:0]       cause;
	logic [7:0]       lsr_cur;
	logic             dlab, loop, has_room, empty;
	logic             push;
	logic [7:0]       push_data;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]       ram_rdata, fifo_rdata;
	logic             byp_q;
	logic [7:0]       byp_data_q;

	assign fill_inc   = fill_q + ONE_C;
	assign rd_inc     = rd_q + ONE_C;
	assign dlab       = lcr_q[LCR_DLAB_BIT];
	assign loop       = mcr_q[MCR_LOOP_BIT];
	assign has_room   = fill_q < DEPTH_C;
	assign empty      = !dr_q && (fill_q == '0);
	assign lsr_cur    = LSR_TEMT_THRE | {7'b0, dr_q};
	assign fifo_rdata = byp_q ? byp_data_q : ram_rdata;
	assign raddr      = rd_d[ADDR_W-1:0];

	always_comb begin
		fill_d    = fill_q;
		rd_d      = rd_q;
		burst_d   = burst_q;
		dr_d      = dr_q;
		dll_d     = dll_q;
		dlm_d     = dlm_q;
		ier_d     = ier_q;
		lcr_d     = lcr_q;
		mcr_d     = mcr_q;
		scr_d     = scr_q;
		push      = 1'b0;
		push_data = req.write_data;
		rsp       = '0;
		if (fire) begin
			case (req.mode)
				MODE_BUS_RD: begin
					burst_d = 1'b0;
					case (req.reg_offset)
						OFF_DATA: begin
							if (dlab) begin
								rsp.read_data = dll_q;
							end else if (rd_q < fill_q) begin
								rsp.read_data = fifo_rdata;
								if (rd_inc == fill_q) begin
									dr_d   = 1'b0;
									fill_d = '0;
									rd_d   = '0;
								end else begin
									rd_d = rd_inc;
								end
							end
						end
						OFF_IER:     rsp.read_data = dlab ? dlm_q : {4'b0, ier_q};
						OFF_IIR_FCR: rsp.read_data = iir_q | IIR_TYPE_BITS;
						OFF_LCR:     rsp.read_data = lcr_q;
						OFF_MCR:     rsp.read_data = mcr_q;
						OFF_LSR:     rsp.read_data = lsr_cur;
						OFF_MSR:     rsp.read_data = MSR_FIXED;
						default:     rsp.read_data = scr_q;
					endcase
				end
				MODE_BUS_WR: begin
					burst_d = 1'b0;
					case (req.reg_offset)
						OFF_DATA: begin
							if (dlab) begin
								dll_d = req.write_data;
							end else if (loop) begin
								push = has_room;
							end else begin
								rsp.tx_valid = 1'b1;
								rsp.tx_byte  = req.write_data;
							end
						end
						OFF_IER: begin
							if (dlab) begin
								dlm_d = req.write_data;
							end else begin
								ier_d = req.write_data[3:0] & IER_MASK;
							end
						end
						OFF_IIR_FCR: begin
							if (req.write_data[FCR_CLR_RX_BIT]) begin
								fill_d = '0;
								rd_d   = '0;
								dr_d   = 1'b0;
							end
						end
						OFF_LCR: lcr_d = req.write_data;
						OFF_MCR: mcr_d = req.write_data;
						OFF_SCR: scr_d = req.write_data;
						default: ;
					endcase
				end
				MODE_HOST_RX: begin
					push_data = req.rx_byte;
					if (!loop && (empty || burst_q) && has_room) begin
						push            = 1'b1;
						rsp.rx_accepted = 1'b1;
						burst_d         = fill_inc < DEPTH_C;
					end else begin
						burst_d = 1'b0;
					end
				end
				default: ;
			endcase
			if (push) begin
				fill_d = fill_inc;
				dr_d   = 1'b1;
			end
		end
		cause = {5'b0, ier_d[IER_RDA_BIT] & dr_d, ier_d[IER_THRE_BIT], 1'b0};
		iir_d = (cause != '0) ? cause : IIR_NONE;
		irq_d = cause != '0;
		rsp.irq_level = irq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rd_q    <= '0;
			burst_q <= 1'b0;
			dr_q    <= 1'b0;
			dll_q   <= '0;
			dlm_q   <= '0;
			ier_q   <= '0;
			iir_q   <= IIR_NONE;
			lcr_q   <= '0;
			mcr_q   <= MCR_RESET;
			scr_q   <= '0;
			byp_q   <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			rd_q    <= rd_d;
			burst_q <= burst_d;
			dr_q    <= dr_d;
			dll_q   <= dll_d;
			dlm_q   <= dlm_d;
			ier_q   <= ier_d;
			iir_q   <= iir_d;
			lcr_q   <= lcr_d;
			mcr_q   <= mcr_d;
			scr_q   <= scr_d;
			byp_q   <= push && (fill_q[ADDR_W-1:0] == raddr);
		end
	end

	// write-to-read forwarding for the entry read on the next transfer
	always_ff @(posedge clk) begin
		byp_data_q <= push_data;
	end

	uart16_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_fifo (
		.clk   (clk),
		.we    (push),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (push_data),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/core/uart_16550_register_model_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_model_core
// 16550-style register file with divisor latches, interrupt logic and a
// receive fifo, driven by bus reads, bus writes and host receive bytes.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall with mode, reg_offset, write_data and
//   rx_byte; mode 0 reads, mode 1 writes, mode 2 offers a host byte
//   output channel: out_valid/out_stall with read_data, irq_level, tx_valid,
//   tx_byte and rx_accepted, one result per input transfer, in order
//   path: an item passes the input register, then the result register
//   throughput: 1 transfer per cycle while the receiver does not stall;
//   register and fifo state is updated in the same cycle an item leaves
//   the input register, and the fifo memory read for the next item is
//   started in that cycle with a forwarding path
//   reset: registers take their 16550 reset values, the fifo is empty and
//   both channels are idle; fifo contents are not cleared
//   receiver stall: the result is held; the input register keeps one more
//   item, after which in_stall rises until the result is taken
// ----------------------------------------------------------------------------
module uart_16550_register_model_core #(
	parameter int RX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [2:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_level,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       rx_accepted
);
	import uart16_pkg::*;

	logic valid_s1;
	req_t req_s1;
	rsp_t rsp;
	rsp_t rsp_q;
	logic out_valid_q;
	logic out_ready;
	logic fire;

	assign out_ready = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				out_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.mode       <= mode;
			req_s1.reg_offset <= reg_offset;
			req_s1.write_data <= write_data;
			req_s1.rx_byte    <= rx_byte;
		end
		if (fire) begin
			rsp_q <= rsp;
		end
	end

	uart16_regfile #(
		.RX_DEPTH (RX_DEPTH)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp)
	);

	assign out_valid   = out_valid_q;
	assign read_data   = rsp_q.read_data;
	assign irq_level   = rsp_q.irq_level;
	assign tx_valid    = rsp_q.tx_valid;
	assign tx_byte     = rsp_q.tx_byte;
	assign rx_accepted = rsp_q.rx_accepted;

	// transmit only from a data-register write, never with a receive
	a_tx_source: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.tx_valid |->
			req_s1.mode == MODE_BUS_WR && req_s1.reg_offset == OFF_DATA && !rsp.rx_accepted)
		else $error("transmit from unexpected access");

	a_rx_source: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.rx_accepted |-> req_s1.mode == MODE_HOST_RX)
		else $error("receive accept outside host offer");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.read_data != 8'h00 |-> req_s1.mode == MODE_BUS_RD)
		else $error("read data on non-read access");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(req_s1))
		else $error("input stage lost a stalled item");

endmodule

/* tb/sv/uart_regs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_regs_checker
// Watches both channels of the 16550-style register model. Every input
// transfer is run through a local model of the register file and the
// receive fifo, and the expected result is queued. Every output transfer is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module uart_regs_checker #(
	parameter int RX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] mode,
	input  logic [2:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_data,
	input  logic       irq_level,
	input  logic       tx_valid,
	input  logic [7:0] tx_byte,
	input  logic       rx_accepted,
	output int         n_mismatch,
	output int         n_outstanding
);
	import uart16_pkg::*;

	localparam int LSR_DR_BIT     = 0;
	localparam int LSR_TEMT_BIT   = 6;
	localparam int FCR_CLR_TX_BIT = 2;
	localparam logic [7:0] CAUSE_RX_DATA = 8'h04;
	localparam logic [7:0] CAUSE_TX_IDLE = 8'h02;

	logic [7:0]  rx_mem [RX_DEPTH];
	int unsigned fill_cnt;
	int unsigned rd_cnt;
	bit          burst_open;
	logic [7:0]  dll;
	logic [7:0]  dlm;
	logic [3:0]  ier;
	logic [7:0]  iir;
	logic [7:0]  fcr;
	logic [7:0]  lcr;
	logic [7:0]  mcr;
	logic [7:0]  lsr;
	logic [7:0]  scr;
	bit          irq;

	rsp_t uart_results_q[$];
	rsp_t want;
	req_t req;

	function automatic void reset_regs();
		fill_cnt   = 0;
		rd_cnt     = 0;
		burst_open = 0;
		dll        = '0;
		dlm        = '0;
		ier        = '0;
		iir        = IIR_NONE;
		fcr        = '0;
		lcr        = '0;
		mcr        = MCR_RESET;
		lsr        = LSR_TEMT_THRE;
		scr        = '0;
		irq        = 0;
	endfunction

	function automatic void rx_store(logic [7:0] b);
		if (fill_cnt < RX_DEPTH) begin
			rx_mem[fill_cnt] = b;
			fill_cnt++;
		end
		lsr[LSR_DR_BIT] = 1'b1;
	endfunction

	function automatic void update_irq();
		logic [7:0] cause;
		cause = '0;
		if (fcr[FCR_CLR_RX_BIT]) begin
			fcr[FCR_CLR_RX_BIT] = 1'b0;
			fill_cnt            = 0;
			rd_cnt              = 0;
			burst_open          = 0;
			lsr[LSR_DR_BIT]     = 1'b0;
		end
		if (fcr[FCR_CLR_TX_BIT]) begin
			fcr[FCR_CLR_TX_BIT] = 1'b0;
			lsr                 = lsr | LSR_TEMT_THRE;
		end
		if (ier[IER_RDA_BIT] && lsr[LSR_DR_BIT])
			cause = cause | CAUSE_RX_DATA;
		if (ier[IER_THRE_BIT] && lsr[LSR_TEMT_BIT])
			cause = cause | CAUSE_TX_IDLE;
		iir = (cause != 0) ? cause : IIR_NONE;
		irq = (cause != 0);
		if (!ier[IER_THRE_BIT])
			lsr = lsr | LSR_TEMT_THRE;
	endfunction

	function automatic logic [7:0] reg_read(logic [2:0] off);
		logic [7:0] v;
		bit         dlab;
		v    = '0;
		dlab = lcr[LCR_DLAB_BIT];
		case (off)
			OFF_DATA: begin
				if (dlab) begin
					v = dll;
				end else if (rd_cnt < fill_cnt) begin
					v = rx_mem[rd_cnt];
					rd_cnt++;
					if (rd_cnt == fill_cnt) begin
						lsr[LSR_DR_BIT] = 1'b0;
						fill_cnt        = 0;
						rd_cnt          = 0;
					end
				end
			end
			OFF_IER:     v = dlab ? dlm : {4'h0, ier};
			OFF_IIR_FCR: v = iir | IIR_TYPE_BITS;
			OFF_LCR:     v = lcr;
			OFF_MCR:     v = mcr;
			OFF_LSR:     v = lsr;
			OFF_MSR:     v = MSR_FIXED;
			default:     v = scr;
		endcase
		return v;
	endfunction

	function automatic rsp_t uart_regs_step(req_t r);
		rsp_t e;
		bit   dlab;
		bit   empty;
		e    = '0;
		dlab = lcr[LCR_DLAB_BIT];
		case (r.mode)
			MODE_BUS_RD: begin
				burst_open  = 0;
				e.read_data = reg_read(r.reg_offset);
				update_irq();
			end
			MODE_BUS_WR: begin
				burst_open = 0;
				case (r.reg_offset)
					OFF_DATA: begin
						if (dlab) begin
							dll = r.write_data;
						end else if (mcr[MCR_LOOP_BIT]) begin
							if (fill_cnt < RX_DEPTH)
								rx_store(r.write_data);
						end else begin
							lsr        = lsr | LSR_TEMT_THRE;
							e.tx_valid = 1'b1;
							e.tx_byte  = r.write_data;
						end
					end
					OFF_IER: begin
						if (dlab)
							dlm = r.write_data;
						else
							ier = r.write_data[3:0] & IER_MASK;
					end
					OFF_IIR_FCR: fcr = r.write_data;
					OFF_LCR:     lcr = r.write_data;
					OFF_MCR:     mcr = r.write_data;
					OFF_SCR:     scr = r.write_data;
					default: ;
				endcase
				update_irq();
			end
			MODE_HOST_RX: begin
				empty = !lsr[LSR_DR_BIT] && fill_cnt == 0;
				if (!mcr[MCR_LOOP_BIT] && (empty || burst_open) && fill_cnt < RX_DEPTH) begin
					rx_store(r.rx_byte);
					e.rx_accepted = 1'b1;
					burst_open    = (fill_cnt < RX_DEPTH);
				end else begin
					burst_open = 0;
				end
				update_irq();
			end
			default: ;
		endcase
		e.irq_level = irq;
		return e;
	endfunction

	function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
		if (exp_v !== got_v) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, exp_v,
					got_v);
		end
	endfunction

	assign req = '{mode: mode, reg_offset: reg_offset, write_data: write_data, rx_byte: rx_byte};

	initial begin
		n_mismatch    = 0;
		n_outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_regs();
			uart_results_q.delete();
			n_outstanding = 0;
		end else begin
			if (in_valid && !in_stall)
				uart_results_q.push_back(uart_regs_step(req));
			if (out_valid && !out_stall) begin
				if (uart_results_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: result transfer with nothing expected", $realtime);
				end else begin
					want = uart_results_q.pop_front();
					check_field("read_data", want.read_data, read_data);
					check_field("irq_level", {7'b0, want.irq_level}, {7'b0, irq_level});
					check_field("tx_valid", {7'b0, want.tx_valid}, {7'b0, tx_valid});
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("rx_accepted", {7'b0, want.rx_accepted}, {7'b0, rx_accepted});
				end
			end
			n_outstanding = uart_results_q.size();
		end
	end

endmodule

/* tb/sv/tb_uart_16550_register_model_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_16550_register_model_core
// Drives bus reads, bus writes and host receive bytes into the register
// model: a directed pass over the register map and corner cases, then four
// phases of random register traffic, rx bursts, loopback runs and fifo
// drains under varying sender idle and receiver stall. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_uart_16550_register_model_core;
	import uart16_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [7:0] LCR_DLAB    = 8'h01 << LCR_DLAB_BIT;
	localparam logic [7:0] MCR_LOOP    = 8'h01 << MCR_LOOP_BIT;
	localparam logic [7:0] FCR_CLEAR   = 8'h06;
	localparam int PHASE_ITEMS = 470;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] mode;
	logic [2:0] reg_offset;
	logic [7:0] write_data;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;
	logic       irq_level;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       rx_accepted;
	int         n_mismatch;
	int         n_outstanding;

	int idle_pct;
	int stall_pct;
	int n_items;

	uart_16550_register_model_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.reg_offset  (reg_offset),
		.write_data  (write_data),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.irq_level   (irq_level),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.rx_accepted (rx_accepted)
	);

	uart_regs_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.reg_offset    (reg_offset),
		.write_data    (write_data),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.irq_level     (irq_level),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.rx_accepted   (rx_accepted),
		.n_mismatch    (n_mismatch),
		.n_outstanding (n_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic drive(input logic [1:0] m, input logic [2:0] off, input logic [7:0] wd,
		input logic [7:0] rb);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		reg_offset <= off;
		write_data <= wd;
		rx_byte    <= rb;
		do @(posedge clk); while (in_stall);
		n_items++;
		@(negedge clk);
	endtask

	task automatic reg_wr(input logic [2:0] off, input logic [7:0] d);
		drive(MODE_BUS_WR, off, d, 8'($urandom));
	endtask

	task automatic reg_rd(input logic [2:0] off);
		drive(MODE_BUS_RD, off, 8'($urandom), 8'($urandom));
	endtask

	task automatic host_rx(input logic [7:0] b);
		drive(MODE_HOST_RX, 3'($urandom), 8'($urandom), b);
	endtask

	function automatic int run_len();
		if ($urandom_range(4) == 0)
			return $urandom_range(56, 70);
		return $urandom_range(1, 8);
	endfunction

	task automatic random_seq();
		int pick;
		int n;
		pick = $urandom_range(99);
		n    = run_len();
		if (pick < 22) begin
			if ($urandom_range(9) < 7)
				reg_wr(OFF_MCR, 8'($urandom) & ~MCR_LOOP);
			repeat (n) host_rx(8'($urandom));
		end else if (pick < 40) begin
			if ($urandom_range(9) < 7)
				reg_wr(OFF_LCR, 8'($urandom) & ~LCR_DLAB);
			repeat (n) reg_rd(OFF_DATA);
		end else if (pick < 52) begin
			reg_wr(OFF_MCR, 8'($urandom) | MCR_LOOP);
			if ($urandom_range(3) == 0)
				host_rx(8'($urandom));
			repeat (n) reg_wr(OFF_DATA, 8'($urandom));
			if ($urandom_range(3) != 0)
				reg_wr(OFF_MCR, 8'($urandom) & ~MCR_LOOP);
		end else if (pick < 60) begin
			reg_wr(OFF_LCR, 8'($urandom) | LCR_DLAB);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(1))
					reg_wr(3'($urandom_range(1)), 8'($urandom));
				else
					reg_rd(3'($urandom_range(1)));
			end
			if ($urandom_range(3) != 0)
				reg_wr(OFF_LCR, 8'($urandom) & ~LCR_DLAB);
		end else if (pick < 70) begin
			reg_wr(OFF_IER, 8'($urandom));
		end else if (pick < 76) begin
			reg_wr(OFF_IIR_FCR, 8'($urandom));
		end else if (pick < 88) begin
			reg_rd(3'($urandom));
		end else if (pick < 95) begin
			reg_wr(3'($urandom), 8'($urandom));
		end else if (pick < 98) begin
			drive(MODE_UNUSED, 3'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			drive(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		int goal;
		idle_pct  = idle;
		stall_pct = stall;
		goal      = n_items + PHASE_ITEMS;
		while (n_items < goal)
			random_seq();
		// hold the sender until every result is back
		in_valid <= 1'b0;
		while (n_outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_BUS_RD;
		reg_offset = OFF_DATA;
		write_data = '0;
		rx_byte    = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		n_items    = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// register map at reset, empty fifo read, iir and msr reads
		reg_rd(OFF_DATA);
		reg_rd(OFF_IIR_FCR);
		reg_rd(OFF_LSR);
		reg_rd(OFF_MSR);
		reg_wr(OFF_IER, 8'hff);
		reg_rd(OFF_IER);
		reg_wr(OFF_LSR, 8'h00);
		reg_wr(OFF_MSR, 8'hff);
		reg_wr(OFF_SCR, 8'ha5);
		// host burst, then refused offer after a bus access
		host_rx(8'h00);
		host_rx(8'hff);
		reg_wr(OFF_LCR, LCR_DLAB);
		reg_wr(OFF_DATA, 8'hff);
		reg_wr(OFF_IER, 8'h00);
		reg_rd(OFF_DATA);
		reg_wr(OFF_LCR, 8'h00);
		host_rx(8'h5a);
		reg_rd(OFF_DATA);
		reg_rd(OFF_DATA);
		// transmit, loopback, fifo clear
		reg_wr(OFF_DATA, 8'h00);
		reg_wr(OFF_MCR, MCR_LOOP);
		host_rx(8'h33);
		reg_wr(OFF_DATA, 8'hff);
		reg_wr(OFF_IIR_FCR, FCR_CLEAR);
		drive(MODE_UNUSED, 3'h7, 8'hff, 8'hff);
		reg_rd(OFF_DATA);

		run_phase(0, 0);
		run_phase(48, 0);
		run_phase(0, 48);
		run_phase(24, 24);

		while (n_outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (n_mismatch == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
